@@ hw/rtl/bldc_hall_commutator_speed_defines.svh @@
// Assertion macros for the hall commutator block.
`ifndef BLDC_HALL_COMMUTATOR_SPEED_DEFINES_SVH
`define BLDC_HALL_COMMUTATOR_SPEED_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BHCS_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BHCS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/bhcs_pkg.sv @@
`default_nettype none

package bhcs_pkg;

	localparam int HISTORY_DEPTH_DEF   = 6;
	localparam int TICK_RATE_DEF       = 10000;
	localparam int SPEED_FRAC_BITS_DEF = 4;

	localparam int PERIOD_W   = 16;
	localparam int TARGET_W   = 10;
	localparam int HALL_W     = 3;
	localparam int PATTERN_W  = 6;
	localparam int ROTOR_W    = 3;
	localparam int SUM_OUT_W  = 19;
	localparam int EDGE_W     = 32;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 64;
	localparam int CFG_DATA_W = 3;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_HALL  = 2'd1,
		OP_DRIVE = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		CFG_ROTOR_OFFSET   = 2'd0,
		CFG_PHASE_LEAD     = 2'd1,
		CFG_SPIN_DIRECTION = 2'd2
	} cfg_index_t;

	localparam logic [2:0] ROTOR_OFFSET_RST   = 3'd0;
	localparam logic [2:0] PHASE_LEAD_RST     = 3'b110;
	localparam logic [1:0] SPIN_DIRECTION_RST = 2'b01;

	// phase enables L1L,L1H,L2L,L2H,L3L,L3H from bit0; last two entries all off
	localparam logic [PATTERN_W-1:0] PHASE_TABLE [8] = '{
		6'h12, 6'h18, 6'h09, 6'h21, 6'h24, 6'h06, 6'h00, 6'h00
	};

	// invalid hall codes map to rotor state 7
	localparam logic [ROTOR_W-1:0] HALL_TO_ROTOR [8] = '{
		3'd7, 3'd5, 3'd3, 3'd4, 3'd1, 3'd0, 3'd2, 3'd7
	};

	// truncating remainder by 6 for the drive sum range -6..18, low 3 bits
	function automatic logic [2:0] mod6_low3(input logic signed [5:0] v);
		logic signed [5:0] r;
		if (v[5]) begin
			r = (v == -6'sd6) ? 6'sd0 : v;
		end else if (v >= 6'sd18) begin
			r = v - 6'sd18;
		end else if (v >= 6'sd12) begin
			r = v - 6'sd12;
		end else if (v >= 6'sd6) begin
			r = v - 6'sd6;
		end else begin
			r = v;
		end
		return r[2:0];
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bldc_hall_commutator_speed.sv @@
// A result is offered in the cycle after its request is accepted.
// Throughput: one request per cycle; s_tready follows m_tready while a result waits.
// The state registers double as the result register, so the speed check
// (one 10-bit by sum-width multiply and compare) is the longest path.
// Reset: arst_n low clears all state, loads register reset values, drops m_tvalid.
`default_nettype none

module bldc_hall_commutator_speed #(
	parameter int HISTORY_DEPTH   = bhcs_pkg::HISTORY_DEPTH_DEF,
	parameter int TICK_RATE       = bhcs_pkg::TICK_RATE_DEF,
	parameter int SPEED_FRAC_BITS = bhcs_pkg::SPEED_FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output      logic                             s_tready,
	// [2:0] hall_bits, [12:3] target_speed, [15:13] zero
	input  wire logic [bhcs_pkg::S_TDATA_W-1:0]   s_tdata,
	// [1:0] opcode
	input  wire logic [1:0]                       s_tuser,
	output      logic                             m_tvalid,
	input  wire logic                             m_tready,
	// [5:0] drive_pattern, [8:6] rotor_state, [27:9] period_sum,
	// [59:28] edge_count, [63:60] zero
	output      logic [bhcs_pkg::M_TDATA_W-1:0]   m_tdata,
	// [0] braking
	output      logic                             m_tuser,
	input  wire logic                             cfg_valid,
	output      logic                             cfg_ready,
	input  wire logic [1:0]                       cfg_index,
	input  wire logic [bhcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int SUM_W  = $clog2(HISTORY_DEPTH * 65535 + 1);
	localparam int PROD_W = bhcs_pkg::TARGET_W + SUM_W;
	localparam logic [PROD_W-1:0] SPEED_LIMIT =
		PROD_W'(TICK_RATE * (2 ** SPEED_FRAC_BITS));

	logic [2:0]                          offset_q;
	logic [2:0]                          lead_q;
	logic [1:0]                          dir_q;
	logic [bhcs_pkg::PERIOD_W-1:0]       tick_q;
	logic [bhcs_pkg::PERIOD_W-1:0]       hist_q [HISTORY_DEPTH];
	logic [SUM_W-1:0]                    sum_q;
	logic [bhcs_pkg::ROTOR_W-1:0]        rotor_q;
	logic [bhcs_pkg::EDGE_W-1:0]         edges_q;
	logic [bhcs_pkg::PATTERN_W-1:0]      pattern_q;
	logic                                braking_q;
	logic                                m_tvalid_q;

	logic                                s_accept;
	logic [bhcs_pkg::HALL_W-1:0]         s_hall;
	logic [bhcs_pkg::TARGET_W-1:0]       s_target;
	logic [PROD_W-1:0]                   prod;
	logic                                fast;
	logic signed [5:0]                   v_base;
	logic signed [5:0]                   v_drive;

	assign s_hall   = s_tdata[2:0];
	assign s_target = s_tdata[12:3];

	assign s_tready  = !m_tvalid_q || m_tready;
	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// with a nonzero target, speed is above it when TICK_RATE * 2^frac > target * sum; empty history is too fast
	assign prod = PROD_W'(s_target) * PROD_W'(sum_q);
	assign fast = (s_target != '0) && ((sum_q == '0) || (SPEED_LIMIT > prod));

	assign v_base = $signed({3'b000, rotor_q}) - $signed({3'b000, offset_q})
		+ $signed({{3{lead_q[2]}}, lead_q}) + 6'sd6;
	assign v_drive = fast ? (v_base - $signed({{4{dir_q[1]}}, dir_q})) : v_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= bhcs_pkg::ROTOR_OFFSET_RST;
			lead_q   <= bhcs_pkg::PHASE_LEAD_RST;
			dir_q    <= bhcs_pkg::SPIN_DIRECTION_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (bhcs_pkg::cfg_index_t'(cfg_index))
				bhcs_pkg::CFG_ROTOR_OFFSET:   offset_q <= cfg_data;
				bhcs_pkg::CFG_PHASE_LEAD:     lead_q   <= cfg_data;
				bhcs_pkg::CFG_SPIN_DIRECTION: dir_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= '0;
			sum_q     <= '0;
			rotor_q   <= '0;
			edges_q   <= '0;
			pattern_q <= '0;
			braking_q <= 1'b0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else if (s_accept) begin
			case (bhcs_pkg::opcode_t'(s_tuser))
				bhcs_pkg::OP_TICK: begin
					if (tick_q != '1) begin
						tick_q <= tick_q + 1'b1;
					end
				end
				bhcs_pkg::OP_HALL: begin
					rotor_q <= bhcs_pkg::HALL_TO_ROTOR[s_hall];
					for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
						hist_q[i] <= hist_q[i+1];
					end
					hist_q[HISTORY_DEPTH-1] <= tick_q;
					// running sum: newest period in, oldest out
					sum_q   <= sum_q + SUM_W'(tick_q) - SUM_W'(hist_q[0]);
					tick_q  <= '0;
					edges_q <= edges_q + 1'b1;
				end
				bhcs_pkg::OP_DRIVE: begin
					pattern_q <= bhcs_pkg::PHASE_TABLE[bhcs_pkg::mod6_low3(v_drive)];
					braking_q <= fast;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = braking_q;
	assign m_tdata  = {4'b0000, edges_q, bhcs_pkg::SUM_OUT_W'(sum_q), rotor_q, pattern_q};

endmodule

`default_nettype wire

@@ hw/rtl/bhcs_checker.sv @@
`default_nettype none

`include "bldc_hall_commutator_speed_defines.svh"

module bhcs_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic [bhcs_pkg::S_TDATA_W-1:0]  s_tdata,
	input wire logic [1:0]                      s_tuser,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [bhcs_pkg::M_TDATA_W-1:0]  m_tdata,
	input wire logic                            m_tuser
);

	logic s_acc;
	assign s_acc = s_tvalid && s_tready;

	`BHCS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	`BHCS_ASSERT_NEXT(a_result_follows, s_acc, m_tvalid, "accepted request gave no result")
	`BHCS_ASSERT_NEXT(a_hall_rotor, s_acc && (s_tuser == bhcs_pkg::OP_HALL), m_tdata[8:6] == bhcs_pkg::HALL_TO_ROTOR[$past(s_tdata[2:0])], "hall edge mapped to wrong rotor state")
	`BHCS_ASSERT_NEXT(a_no_brake_unlimited, s_acc && (s_tuser == bhcs_pkg::OP_DRIVE) && (s_tdata[12:3] == 10'd0), !m_tuser, "braking with unlimited target")

endmodule

bind bldc_hall_commutator_speed bhcs_checker u_bhcs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

@@ dv/bldc_hall_commutator_speed_test.sv @@
`default_nettype none

module bldc_hall_commutator_speed_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int TICKS_PER_SEC = 10000;
	localparam int SPEED_FRAC = 4;
	localparam int PERIOD_SLOTS = 6;
	localparam int HOLD_CYCLES = 300;

	localparam logic [5:0] PHASE_MAP [8] = '{
		6'h12, 6'h18, 6'h09, 6'h21, 6'h24, 6'h06, 6'h00, 6'h00
	};
	localparam logic [2:0] HALL_MAP [8] = '{
		3'd7, 3'd5, 3'd3, 3'd4, 3'd1, 3'd0, 3'd2, 3'd7
	};
	// hall code that reads as rotor state 0..5, for well-formed rotation
	localparam logic [2:0] ROTOR_HALL [6] = '{3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1};

	typedef struct packed {
		logic [5:0]  pattern;
		logic        brake;
		logic [2:0]  rotor;
		logic [18:0] psum;
		logic [31:0] edges;
	} status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid;
	logic s_tready;
	logic [bhcs_pkg::S_TDATA_W-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [bhcs_pkg::M_TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [bhcs_pkg::CFG_DATA_W-1:0] cfg_data;

	logic calm;
	logic hold_go;
	int hold_left;
	int errors;
	int items_sent;
	int hall_phase;

	// commutator mirror
	logic [15:0] tick_cnt;
	logic [15:0] periods [PERIOD_SLOTS];
	logic [2:0] rotor_q;
	logic [31:0] edges_q;
	logic [5:0] pattern_q;
	logic brake_q;
	logic [2:0] offset_q;
	logic signed [2:0] lead_q;
	logic signed [1:0] dir_q;

	status_t awaited_status [$];

	bldc_hall_commutator_speed dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic longint period_total();
		longint s;
		s = 0;
		for (int i = 0; i < PERIOD_SLOTS; i++)
			s += periods[i];
		return s;
	endfunction

	function automatic status_t commutate(logic [1:0] op, logic [2:0] hall, logic [9:0] target);
		status_t r;
		int v;
		longint s;
		bit fast;
		case (op)
			bhcs_pkg::OP_TICK: begin
				if (tick_cnt != 16'hFFFF)
					tick_cnt++;
			end
			bhcs_pkg::OP_HALL: begin
				rotor_q = HALL_MAP[hall];
				for (int i = 1; i < PERIOD_SLOTS; i++)
					periods[i-1] = periods[i];
				periods[PERIOD_SLOTS-1] = tick_cnt;
				tick_cnt = '0;
				edges_q++;
			end
			bhcs_pkg::OP_DRIVE: begin
				v = int'(rotor_q) - int'(offset_q) + int'(lead_q) + 6;
				fast = 1'b0;
				if (target != 0) begin
					s = period_total();
					fast = (s == 0) ||
						(longint'(TICKS_PER_SEC) * (1 << SPEED_FRAC) > longint'(target) * s);
				end
				if (fast)
					v -= int'(dir_q);
				v = v % 6;
				pattern_q = PHASE_MAP[v[2:0]];
				brake_q = fast;
			end
			default: ;
		endcase
		r.pattern = pattern_q;
		r.brake = brake_q;
		r.rotor = rotor_q;
		r.psum = 19'(period_total());
		r.edges = edges_q;
		return r;
	endfunction

	// targets zero, random or near the present speed so that both sides of the compare show up
	function automatic logic [9:0] pick_target();
		longint s;
		int t;
		s = period_total();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return 10'($urandom_range(1, 1023));
			default: begin
				if (s == 0)
					return 10'($urandom_range(0, 1023));
				t = int'(longint'(TICKS_PER_SEC * (1 << SPEED_FRAC)) / s);
				t = t + $urandom_range(0, 4) - 2;
				if (t < 1)
					t = 1;
				if (t > 1023)
					t = 1023;
				return t[9:0];
			end
		endcase
	endfunction

	task automatic flag_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_status.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h/%b",
					$time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = awaited_status.pop_front();
				flag_field("drive_pattern", want.pattern, m_tdata[5:0]);
				flag_field("braking", want.brake, m_tuser);
				flag_field("rotor_state", want.rotor, m_tdata[8:6]);
				flag_field("period_sum", want.psum, m_tdata[27:9]);
				flag_field("edge_count", want.edges, m_tdata[59:28]);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
		end else if (hold_go) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_tready <= calm || ($urandom_range(0, 99) >= 14);
		end
	end

	task automatic send_req(logic [1:0] op, logic [2:0] hall, logic [9:0] target);
		while (!calm && $urandom_range(0, 99) < 14) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, target, hall};
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		awaited_status.push_back(commutate(op, hall, target));
		items_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_status.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(bhcs_pkg::cfg_index_t idx, logic [2:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			bhcs_pkg::CFG_ROTOR_OFFSET: offset_q = val;
			bhcs_pkg::CFG_PHASE_LEAD: lead_q = val;
			bhcs_pkg::CFG_SPIN_DIRECTION: dir_q = val[1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [2:0] offset, logic signed [2:0] lead,
			logic signed [1:0] dir);
		wait_idle();
		write_reg(bhcs_pkg::CFG_ROTOR_OFFSET, offset);
		write_reg(bhcs_pkg::CFG_PHASE_LEAD, lead);
		write_reg(bhcs_pkg::CFG_SPIN_DIRECTION, {1'b0, dir});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_traffic(int n);
		int start;
		start = items_sent;
		while (items_sent - start < n) begin
			if ($urandom_range(0, 99) < 80) begin
				repeat ($urandom_range(0, 40))
					send_req(bhcs_pkg::OP_TICK, 3'($urandom), 10'($urandom));
				hall_phase = (hall_phase + (($urandom_range(0, 3) == 0) ? 5 : 1)) % 6;
				send_req(bhcs_pkg::OP_HALL, ROTOR_HALL[hall_phase], 10'($urandom));
				repeat ($urandom_range(1, 3))
					send_req(bhcs_pkg::OP_DRIVE, 3'($urandom), pick_target());
			end else begin
				send_req(2'($urandom_range(0, 3)), 3'($urandom), 10'($urandom));
			end
		end
	endtask

	task automatic test_reset_state();
		send_req(OP_UNUSED, 3'd7, 10'd1023);
		send_req(bhcs_pkg::OP_DRIVE, 3'd0, 10'd0);
		send_req(bhcs_pkg::OP_DRIVE, 3'd0, 10'd1);	// empty history reads as too fast
		send_req(bhcs_pkg::OP_TICK, 3'd0, 10'd0);
	endtask

	task automatic test_hall_codes();
		for (int h = 0; h < 8; h++) begin
			send_req(bhcs_pkg::OP_HALL, 3'(h), 10'($urandom));
			send_req(bhcs_pkg::OP_DRIVE, 3'(h), h[0] ? 10'd1023 : 10'd0);
		end
	endtask

	task automatic test_negative_drive();
		set_config(3'd7, -3'sd2, 2'sd1);
		send_req(bhcs_pkg::OP_HALL, 3'd5, 10'd0);
		send_req(bhcs_pkg::OP_DRIVE, 3'd0, 10'd0);
		send_req(bhcs_pkg::OP_DRIVE, 3'd0, 10'd1);
		set_config(3'd7, -3'sd2, -2'sd1);
		send_req(bhcs_pkg::OP_DRIVE, 3'd0, 10'd1);
		send_req(bhcs_pkg::OP_HALL, 3'd6, 10'd0);
		send_req(bhcs_pkg::OP_DRIVE, 3'd0, 10'd0);
	endtask

	task automatic test_random_configs();
		set_config(3'd0, -3'sd2, 2'sd1);
		random_traffic(90);
		set_config(3'd7, 3'sd2, -2'sd1);
		random_traffic(90);
		set_config(3'd0, -3'sd2, 2'sd0);
		calm = 1'b1;
		random_traffic(45);
		calm = 1'b0;
		random_traffic(45);
		set_config(3'd3, 3'sd1, 2'sd1);
		random_traffic(90);
		set_config(3'($urandom_range(0, 7)), 3'($urandom_range(0, 4) - 2),
			2'($urandom_range(0, 2) - 1));
		random_traffic(90);
	endtask

	task automatic test_backpressure();
		hold_go <= 1'b1;
		s_tvalid <= 1'b0;
		@(posedge clk);
		hold_go <= 1'b0;
		repeat (40)
			send_req(2'($urandom_range(0, 2)), 3'($urandom), pick_target());
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		hold_go = 1'b0;
		errors = 0;
		items_sent = 0;
		hall_phase = 0;
		tick_cnt = '0;
		for (int i = 0; i < PERIOD_SLOTS; i++)
			periods[i] = '0;
		rotor_q = '0;
		edges_q = '0;
		pattern_q = '0;
		brake_q = 1'b0;
		offset_q = bhcs_pkg::ROTOR_OFFSET_RST;
		lead_q = bhcs_pkg::PHASE_LEAD_RST;
		dir_q = bhcs_pkg::SPIN_DIRECTION_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_hall_codes();
		test_negative_drive();
		test_random_configs();
		test_backpressure();
		wait_idle();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
